// ----- hdl/atpc_pkg.sv -----
package atpc_pkg;

    // Phase codes
    localparam logic [1:0] PH_SET_MAXG  = 2'd0;
    localparam logic [1:0] PH_SET_CLR   = 2'd1;
    localparam logic [1:0] PH_RUN       = 2'd2;

    // Light codes
    localparam logic [1:0] LIGHT_RED    = 2'd1;
    localparam logic [1:0] LIGHT_GREEN  = 2'd2;

    // Set-up limits and defaults
    localparam logic [6:0]  MAXG_HI      = 7'd99;
    localparam logic [6:0]  MAXG_LO      = 7'd1;
    localparam logic [6:0]  MAXG_DEF     = 7'd2;
    localparam logic [9:0]  CLR_HI       = 10'd999;
    localparam logic [9:0]  CLR_STEP     = 10'd5;
    localparam logic [9:0]  CLR_DEF      = 10'd15;

    // Timing constants in ms
    localparam logic [22:0] MS_PER_MIN   = 23'd60000;
    localparam logic [22:0] MS_HALF_MIN  = 23'd30000;
    localparam logic [22:0] MIN_HOLD     = 23'd15000;
    localparam logic [22:0] GREEN_EMPTY  = 23'd20000;
    localparam logic [22:0] ELAPSED_MAX  = 23'h7FFFFF;
    localparam logic [16:0] FRESH_LIMIT  = 17'd60000;
    localparam logic [16:0] STALE_AGE    = 17'd60001;

    typedef struct packed {
        logic       btn_up;
        logic       btn_down;
        logic       btn_accept;
        logic       btn_cancel;
        logic       coord_ready;
        logic [1:0] light_state;
        logic       detect_fresh;
        logic [7:0] cars_waiting;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [6:0]  max_green;
        logic [9:0]  clearance;
        logic        first_run;
        logic [22:0] elapsed;
        logic [16:0] data_age;
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [6:0] max_green_min;
        logic [9:0] clearance_s;
        logic       configure_pulse;
        logic       change_request;
        logic       exit_to_menu;
    } result_t;

endpackage

// ----- hdl/atpc_step.sv -----
module atpc_step (
    input  atpc_pkg::ctrl_state_t st,
    input  atpc_pkg::in_item_t    item,
    output atpc_pkg::ctrl_state_t st_next,
    output atpc_pkg::result_t     res
);
    import atpc_pkg::*;

    logic [22:0] limit;
    logic [22:0] half_limit;
    logic [10:0] clr_sum;
    logic [9:0]  clr_up;
    logic [6:0]  mg_up;
    logic [22:0] elapsed_step;
    logic        fresh;
    logic        early;
    logic        change;

    // Green limit and its half from the stored minutes
    assign limit      = {16'd0, st.max_green} * MS_PER_MIN;
    assign half_limit = {16'd0, st.max_green} * MS_HALF_MIN;

    always_comb begin
        st_next = st;
        res     = '0;
        clr_sum = 11'(st.clearance) + 11'(CLR_STEP);
        clr_up  = st.clearance;
        mg_up   = st.max_green;
        elapsed_step = st.elapsed;
        fresh   = 1'b0;
        early   = 1'b0;
        change  = 1'b0;

        // Data age counts every tick up to the stale age, cleared by a detection while running
        if (!item.btn_cancel && st.phase == PH_RUN && item.detect_fresh) begin
            st_next.data_age = '0;
        end else if (st.data_age < STALE_AGE) begin
            st_next.data_age = st.data_age + 17'd1;
        end else begin
            st_next.data_age = STALE_AGE;
        end
        fresh = (st_next.data_age <= FRESH_LIMIT);

        if (item.btn_cancel) begin
            st_next.phase     = PH_SET_MAXG;
            st_next.max_green = MAXG_DEF;
            st_next.clearance = CLR_DEF;
            st_next.first_run = 1'b1;
            st_next.elapsed   = '0;
            res.exit_to_menu  = 1'b1;
        end else begin
            case (st.phase)
                PH_SET_CLR: begin
                    // up first, then down, saturating
                    if (item.btn_up) begin
                        clr_up = (clr_sum > 11'(CLR_HI)) ? CLR_HI : clr_sum[9:0];
                    end
                    if (item.btn_down) begin
                        st_next.clearance = (clr_up >= CLR_STEP) ? clr_up - CLR_STEP : '0;
                    end else begin
                        st_next.clearance = clr_up;
                    end
                    if (item.btn_accept) begin
                        st_next.phase       = PH_RUN;
                        st_next.first_run   = 1'b1;
                        st_next.elapsed     = '0;
                        res.configure_pulse = 1'b1;
                    end
                end
                PH_RUN: begin
                    if (item.coord_ready) begin
                        if (st.first_run) begin
                            elapsed_step = '0;
                        end else if (st.elapsed < ELAPSED_MAX) begin
                            elapsed_step = st.elapsed + 23'd1;
                        end
                        st_next.first_run = 1'b0;
                        // early change on fresh data
                        if (fresh && elapsed_step > MIN_HOLD) begin
                            if (item.light_state == LIGHT_RED && item.cars_waiting != 8'd0) begin
                                early = (elapsed_step >= half_limit);
                            end else if (item.light_state == LIGHT_GREEN
                                         && item.cars_waiting == 8'd0) begin
                                early = (elapsed_step >= GREEN_EMPTY);
                            end
                        end
                        change = early || (elapsed_step >= limit);
                        st_next.elapsed    = change ? '0 : elapsed_step;
                        res.change_request = change;
                    end else begin
                        st_next.first_run = 1'b1;
                    end
                end
                default: begin
                    // set max green; unused code behaves the same
                    st_next.phase = PH_SET_MAXG;
                    if (item.btn_up) begin
                        mg_up = (st.max_green >= MAXG_HI) ? MAXG_HI : st.max_green + 7'd1;
                    end
                    if (item.btn_down) begin
                        st_next.max_green = (mg_up > MAXG_LO) ? mg_up - 7'd1 : MAXG_LO;
                    end else begin
                        st_next.max_green = mg_up;
                    end
                    if (item.btn_accept) begin
                        st_next.phase = PH_SET_CLR;
                    end
                end
            endcase
        end

        res.phase         = st_next.phase;
        res.max_green_min = st_next.max_green;
        res.clearance_s   = st_next.clearance;
    end

endmodule

// ----- hdl/adaptive_traffic_phase_controller.sv -----
// Each request is held in the input register, then its result in the result register.
// Throughput: one tick request per cycle while the result is taken; the single-pass step logic between the
// two registers sets this rate, and the result register frees while it is taken.
// Reset: synchronous active-low aresetn empties both stages and loads the set-up
// defaults (max green 2 min, clearance 15 s, data marked stale).
module adaptive_traffic_phase_controller (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_btn_up,
    input  logic       s_btn_down,
    input  logic       s_btn_accept,
    input  logic       s_btn_cancel,
    input  logic       s_coord_ready,
    input  logic [1:0] s_light_state,
    input  logic       s_detect_fresh,
    input  logic [7:0] s_cars_waiting,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_phase,
    output logic [6:0] m_max_green_min,
    output logic [9:0] m_clearance_s,
    output logic       m_configure_pulse,
    output logic       m_change_request,
    output logic       m_exit_to_menu
);
    import atpc_pkg::*;

    in_item_t    in_reg;
    logic        in_valid_reg;
    ctrl_state_t st_reg;
    ctrl_state_t st_next;
    result_t     res_next;
    result_t     out_reg;
    logic        out_valid_reg;
    logic        fire;

    // Step the held request when the result register is free or being taken
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    atpc_step u_step (
        .st      (st_reg),
        .item    (in_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_reg <= '{btn_up: s_btn_up, btn_down: s_btn_down,
                        btn_accept: s_btn_accept, btn_cancel: s_btn_cancel,
                        coord_ready: s_coord_ready, light_state: s_light_state,
                        detect_fresh: s_detect_fresh, cars_waiting: s_cars_waiting};
        end
    end

    // Controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{phase: PH_SET_MAXG, max_green: MAXG_DEF, clearance: CLR_DEF,
                        first_run: 1'b1, elapsed: '0, data_age: STALE_AGE};
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (fire) begin
            out_reg <= res_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_phase           = out_reg.phase;
    assign m_max_green_min   = out_reg.max_green_min;
    assign m_clearance_s     = out_reg.clearance_s;
    assign m_configure_pulse = out_reg.configure_pulse;
    assign m_change_request  = out_reg.change_request;
    assign m_exit_to_menu    = out_reg.exit_to_menu;

endmodule

// ----- hdl/atpc_checker.sv -----
module atpc_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_phase,
    input  logic [6:0] m_max_green_min,
    input  logic [9:0] m_clearance_s,
    input  logic       m_configure_pulse,
    input  logic       m_change_request,
    input  logic       m_exit_to_menu
);
    import atpc_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_phase) && $stable(m_change_request))
        else $error("result changed while stalled");

    // Cancel restores defaults and fires nothing else
    a_cancel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_exit_to_menu |-> m_phase == PH_SET_MAXG && m_max_green_min == MAXG_DEF
            && m_clearance_s == CLR_DEF && !m_configure_pulse && !m_change_request)
        else $error("cancel result wrong");

    // Pulses only land in running phase
    a_pulse_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_configure_pulse || m_change_request) |-> m_phase == PH_RUN)
        else $error("pulse outside running phase");

    // Set-up values stay within limits
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_max_green_min >= MAXG_LO && m_max_green_min <= MAXG_HI
            && m_clearance_s <= CLR_HI && m_phase != 2'd3)
        else $error("set-up value out of range");

    // At most one pulse per result
    a_one_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_configure_pulse, m_change_request, m_exit_to_menu}))
        else $error("more than one pulse");

endmodule

bind adaptive_traffic_phase_controller atpc_checker u_atpc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_phase           (m_phase),
    .m_max_green_min   (m_max_green_min),
    .m_clearance_s     (m_clearance_s),
    .m_configure_pulse (m_configure_pulse),
    .m_change_request  (m_change_request),
    .m_exit_to_menu    (m_exit_to_menu)
);
